// ===== src/lfu_pkg.sv =====
// Package for the LFU cache table: sizes, derived widths and command codes.
// Used by lfu_cache_table and by its port checker; depends on nothing.
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 16;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int REC_W = IDX_W;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CAP_W = 5;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_PROBE = 2'd2
    } t_cmd;

endpackage

// ===== src/lfu_cache_table.sv =====
// Fully associative key/value cache with LFU replacement and LRU tie-break.
// One sequencer with a shared key/count compare unit; uses lfu_pkg.
//
// Usage: an item is taken when start is high and busy is low. The entries are
// scanned one per cycle through a single key match and victim compare, so
// busy stays high while all lfu_pkg::ENTRIES entries are scanned and through
// the update state. The result follows in the next cycle on o_strobe for
// exactly one cycle and cannot be held off; a new item may be started in that
// same cycle. The capacity register is written through i_cfg_valid/o_cfg_ready
// while the block is idle; zero acts as 1 and values above ENTRIES as ENTRIES.
module lfu_cache_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  logic [lfu_pkg::DATA_W-1:0]  i_value,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]   i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_hit,
    output logic [lfu_pkg::DATA_W-1:0]  o_read_value,
    output logic                        o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]   o_evicted_key,
    output logic [lfu_pkg::OCC_W-1:0]   o_occupancy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state r_state;

    // entry storage
    logic                        r_valid [lfu_pkg::ENTRIES];
    logic [lfu_pkg::KEY_W-1:0]   r_ekey  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]  r_edata [lfu_pkg::ENTRIES];
    logic [lfu_pkg::COUNT_W-1:0] r_ecnt  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::REC_W-1:0]   r_rec   [lfu_pkg::ENTRIES];
    logic [lfu_pkg::OCC_W-1:0]   r_total;
    logic [lfu_pkg::CAP_W-1:0]   r_cap;

    // current item
    lfu_pkg::t_cmd               r_cmd;
    logic [lfu_pkg::KEY_W-1:0]   r_key;
    logic [lfu_pkg::DATA_W-1:0]  r_value;
    logic [lfu_pkg::IDX_W-1:0]   r_idx;

    // scan results
    logic                        r_hit;
    logic [lfu_pkg::IDX_W-1:0]   r_hit_idx;
    logic [lfu_pkg::DATA_W-1:0]  r_hit_data;
    logic [lfu_pkg::COUNT_W-1:0] r_hit_cnt;
    logic [lfu_pkg::REC_W-1:0]   r_hit_rec;
    logic                        r_free_ok;
    logic [lfu_pkg::IDX_W-1:0]   r_free_idx;
    logic                        r_vic_ok;
    logic [lfu_pkg::IDX_W-1:0]   r_vic_idx;
    logic [lfu_pkg::KEY_W-1:0]   r_vic_key;
    logic [lfu_pkg::COUNT_W-1:0] r_vic_cnt;
    logic [lfu_pkg::REC_W-1:0]   r_vic_rec;

    // registered result
    logic                        r_strobe;
    logic                        r_o_hit;
    logic [lfu_pkg::DATA_W-1:0]  r_o_rd;
    logic                        r_o_ev;
    logic [lfu_pkg::KEY_W-1:0]   r_o_evk;

    // entry seen by the shared compare unit this cycle
    logic                        cur_valid;
    logic [lfu_pkg::KEY_W-1:0]   cur_key;
    logic [lfu_pkg::COUNT_W-1:0] cur_cnt;
    logic [lfu_pkg::REC_W-1:0]   cur_rec;
    logic                        cur_match;
    logic                        cur_better;

    // update decisions
    logic [lfu_pkg::OCC_W-1:0]   cap_eff;
    logic                        do_touch;
    logic                        do_insert;
    logic                        do_evict;
    logic [lfu_pkg::IDX_W-1:0]   ins_idx;
    logic [lfu_pkg::COUNT_W-1:0] cnt_inc;
    logic                        n_valid [lfu_pkg::ENTRIES];
    logic [lfu_pkg::REC_W-1:0]   n_rec   [lfu_pkg::ENTRIES];
    logic [lfu_pkg::OCC_W-1:0]   n_total;
    logic                        n_o_hit;
    logic [lfu_pkg::DATA_W-1:0]  n_o_rd;

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_rd;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_evk;
    assign o_occupancy   = r_total;

    assign cur_valid = r_valid[r_idx];
    assign cur_key   = r_ekey[r_idx];
    assign cur_cnt   = r_ecnt[r_idx];
    assign cur_rec   = r_rec[r_idx];
    assign cur_match = cur_valid && (cur_key == r_key);
    // lower count wins, older entry wins a tie
    assign cur_better = cur_valid && (!r_vic_ok || (cur_cnt < r_vic_cnt) ||
                        ((cur_cnt == r_vic_cnt) && (cur_rec > r_vic_rec)));

    always_comb begin
        priority if (r_cap == lfu_pkg::CAP_W'(0)) begin
            cap_eff = lfu_pkg::OCC_W'(1);
        end else if (lfu_pkg::OCC_W'(r_cap) > lfu_pkg::OCC_W'(lfu_pkg::ENTRIES)) begin
            cap_eff = lfu_pkg::OCC_W'(lfu_pkg::ENTRIES);
        end else begin
            cap_eff = lfu_pkg::OCC_W'(r_cap);
        end
    end

    assign cnt_inc = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + lfu_pkg::COUNT_W'(1);

    always_comb begin
        do_touch = 1'b0;
        do_evict = 1'b0;
        n_o_hit  = 1'b0;
        n_o_rd   = '0;
        unique case (r_cmd)
            lfu_pkg::CMD_PUT: begin
                n_o_hit  = r_hit;
                do_touch = r_hit;
                do_evict = !r_hit && (r_total >= cap_eff) && r_vic_ok;
            end
            lfu_pkg::CMD_GET: begin
                n_o_hit  = r_hit;
                do_touch = r_hit;
                n_o_rd   = r_hit ? r_hit_data : '0;
            end
            lfu_pkg::CMD_PROBE: begin
                n_o_hit = r_hit;
                n_o_rd  = r_hit ? r_hit_data : '0;
            end
            default: begin
            end
        endcase
        do_insert = (r_cmd == lfu_pkg::CMD_PUT) && !r_hit && (do_evict || r_free_ok);
        // new key takes the lowest free slot once the victim is gone
        if (do_evict && (!r_free_ok || (r_vic_idx < r_free_idx))) begin
            ins_idx = r_vic_idx;
        end else begin
            ins_idx = r_free_idx;
        end
        n_total = r_total - lfu_pkg::OCC_W'(do_evict) + lfu_pkg::OCC_W'(do_insert);
    end

    // recency ranks of all entries change in parallel, one compare per entry
    always_comb begin
        for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_rec[i]   = r_rec[i];
            if (do_touch) begin
                if (lfu_pkg::IDX_W'(i) == r_hit_idx) begin
                    n_rec[i] = '0;
                end else if (r_valid[i] && (r_rec[i] < r_hit_rec)) begin
                    n_rec[i] = r_rec[i] + lfu_pkg::REC_W'(1);
                end
            end else if (do_insert) begin
                if (lfu_pkg::IDX_W'(i) == ins_idx) begin
                    n_valid[i] = 1'b1;
                    n_rec[i]   = '0;
                end else if (do_evict && (lfu_pkg::IDX_W'(i) == r_vic_idx)) begin
                    n_valid[i] = 1'b0;
                end else if (r_valid[i]) begin
                    n_rec[i] = r_rec[i] + lfu_pkg::REC_W'(1)
                             - lfu_pkg::REC_W'(do_evict && (r_rec[i] > r_vic_rec));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_total  <= '0;
            r_cap    <= lfu_pkg::CAP_W'(lfu_pkg::ENTRIES);
            r_idx    <= '0;
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_strobe <= (r_state == S_UPDATE);
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_SCAN;
                        r_idx   <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_idx == lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1)) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_idx <= r_idx + lfu_pkg::IDX_W'(1);
                    end
                end
                S_UPDATE: begin
                    r_state  <= S_IDLE;
                    r_total  <= n_total;
                    for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
                        r_valid[i] <= n_valid[i];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: item, scan trackers, entry contents and result fields
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd     <= lfu_pkg::t_cmd'(i_command);
            r_key     <= i_key;
            r_value   <= i_value;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_vic_ok  <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (cur_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_idx;
                r_hit_data <= r_edata[r_idx];
                r_hit_cnt  <= cur_cnt;
                r_hit_rec  <= cur_rec;
            end
            if (!cur_valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (cur_better) begin
                r_vic_ok  <= 1'b1;
                r_vic_idx <= r_idx;
                r_vic_key <= cur_key;
                r_vic_cnt <= cur_cnt;
                r_vic_rec <= cur_rec;
            end
        end
        if (r_state == S_UPDATE) begin
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
                r_rec[i] <= n_rec[i];
            end
            if (do_touch) begin
                r_ecnt[r_hit_idx] <= cnt_inc;
                if (r_cmd == lfu_pkg::CMD_PUT) begin
                    r_edata[r_hit_idx] <= r_value;
                end
            end
            if (do_insert) begin
                r_ekey[ins_idx]  <= r_key;
                r_edata[ins_idx] <= r_value;
                r_ecnt[ins_idx]  <= lfu_pkg::COUNT_W'(1);
            end
            r_o_hit <= n_o_hit;
            r_o_rd  <= n_o_rd;
            r_o_ev  <= do_evict;
            r_o_evk <= do_evict ? r_vic_key : '0;
        end
    end

endmodule

// ===== src/lfu_checker.sv =====
// Port checker for lfu_cache_table, attached by the bind at the end.
// Sees the top-level ports only; uses lfu_pkg for the entry count.
module lfu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic                        o_hit,
    input logic [lfu_pkg::DATA_W-1:0]  o_read_value,
    input logic                        o_evicted,
    input logic [lfu_pkg::OCC_W-1:0]   o_occupancy
);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("item finished without a result");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_occupancy <= lfu_pkg::OCC_W'(lfu_pkg::ENTRIES)))
        else $error("occupancy above entry count");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_evicted || !o_hit)) |-> (!o_hit || !o_evicted) &&
        (o_hit || (o_read_value == '0)))
        else $error("eviction on a hit or data on a miss");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_hit        (o_hit),
    .o_read_value (o_read_value),
    .o_evicted    (o_evicted),
    .o_occupancy  (o_occupancy)
);

// ===== tb/sv/lfu_cache_table_test.sv =====
// Self-checking testbench for lfu_cache_table: directed and random put/get/probe
// traffic, checked against a behavioral LFU cache kept alongside the block.
// Depends on lfu_pkg and lfu_cache_table only.
module lfu_cache_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE     = 2'd3;
    localparam int         CYCLE_LIMIT  = 4_000_000;
    localparam int         RANDOM_ITEMS = 1100;
    localparam int         POOL_SIZE    = 20;
    localparam int         HOT_GETS     = 40;
    localparam int         SETTLE       = lfu_pkg::ENTRIES + 4;

    typedef struct packed {
        logic                       hit;
        logic [lfu_pkg::DATA_W-1:0] read_value;
        logic                       evicted;
        logic [lfu_pkg::KEY_W-1:0]  evicted_key;
        logic [lfu_pkg::OCC_W-1:0]  occupancy;
    } t_reply;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  i_command;
    logic [lfu_pkg::KEY_W-1:0]   i_key;
    logic [lfu_pkg::DATA_W-1:0]  i_value;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [lfu_pkg::CAP_W-1:0]   i_cfg_data;
    logic                        o_strobe;
    logic                        o_hit;
    logic [lfu_pkg::DATA_W-1:0]  o_read_value;
    logic                        o_evicted;
    logic [lfu_pkg::KEY_W-1:0]   o_evicted_key;
    logic [lfu_pkg::OCC_W-1:0]   o_occupancy;

    // Behavioral copy of the cache contents.
    logic                        slot_valid [lfu_pkg::ENTRIES];
    logic [lfu_pkg::KEY_W-1:0]   slot_key   [lfu_pkg::ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]  slot_data  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::COUNT_W-1:0] slot_uses  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::REC_W-1:0]   slot_age   [lfu_pkg::ENTRIES];
    int                          live_slots;
    logic [lfu_pkg::CAP_W-1:0]   capacity_reg;

    t_reply cache_replies [$];
    int     mismatches  = 0;
    int     cycle_count = 0;

    lfu_cache_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .o_occupancy   (o_occupancy)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int lookup_slot(logic [lfu_pkg::KEY_W-1:0] key);
        int i;
        int s;
        s = -1;
        for (i = 0; i < lfu_pkg::ENTRIES; i++)
            if (s < 0 && slot_valid[i] && slot_key[i] == key)
                s = i;
        return s;
    endfunction

    // Make slot s most recent; valid entries ranked ahead of it age by one.
    function automatic void mark_recent(int s, bit was_valid);
        int i;
        int old;
        old = was_valid ? int'(slot_age[s]) : lfu_pkg::ENTRIES;
        for (i = 0; i < lfu_pkg::ENTRIES; i++)
            if (i != s && slot_valid[i] && int'(slot_age[i]) < old)
                slot_age[i]++;
        slot_age[s] = '0;
    endfunction

    function automatic void use_slot(int s);
        if (slot_uses[s] != '1)
            slot_uses[s]++;
        mark_recent(s, 1'b1);
    endfunction

    function automatic t_reply lfu_apply(logic [1:0] cmd, logic [lfu_pkg::KEY_W-1:0] key,
                                         logic [lfu_pkg::DATA_W-1:0] val);
        t_reply r;
        int     cap;
        int     s;
        int     v;
        int     i;
        r   = '0;
        cap = (capacity_reg == '0) ? 1 :
              (int'(capacity_reg) > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(capacity_reg);
        if (cmd != CMD_NONE) begin
            s     = lookup_slot(key);
            r.hit = (s >= 0);
            if (cmd == lfu_pkg::CMD_PUT) begin
                if (s >= 0) begin
                    slot_data[s] = val;
                    use_slot(s);
                end else begin
                    if (live_slots >= cap) begin
                        // victim: lowest count, oldest among equal counts
                        v = -1;
                        for (i = 0; i < lfu_pkg::ENTRIES; i++) begin
                            if (!slot_valid[i])
                                continue;
                            if (v < 0)
                                v = i;
                            else if (slot_uses[i] < slot_uses[v] ||
                                     (slot_uses[i] == slot_uses[v] &&
                                      slot_age[i] > slot_age[v]))
                                v = i;
                        end
                        if (v >= 0) begin
                            r.evicted     = 1'b1;
                            r.evicted_key = slot_key[v];
                            slot_valid[v] = 1'b0;
                            live_slots--;
                            for (i = 0; i < lfu_pkg::ENTRIES; i++)
                                if (slot_valid[i] && slot_age[i] > slot_age[v])
                                    slot_age[i]--;
                        end
                    end
                    s = -1;
                    for (i = 0; i < lfu_pkg::ENTRIES; i++)
                        if (s < 0 && !slot_valid[i])
                            s = i;
                    if (s >= 0) begin
                        slot_key[s]  = key;
                        slot_data[s] = val;
                        slot_uses[s] = lfu_pkg::COUNT_W'(1);
                        mark_recent(s, 1'b0);
                        slot_valid[s] = 1'b1;
                        live_slots++;
                    end
                end
            end else if (s >= 0) begin
                r.read_value = slot_data[s];
                if (cmd == lfu_pkg::CMD_GET)
                    use_slot(s);
            end
        end
        r.occupancy = lfu_pkg::OCC_W'(live_slots);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_strobe) begin
            if (cache_replies.size() == 0) begin
                report_mismatch("result with nothing pending");
            end else begin
                want = cache_replies[0];
                cache_replies.delete(0);
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, want %0b", o_hit, want.hit));
                if (o_read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              o_read_value, want.read_value));
                if (o_evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %0b, want %0b",
                                              o_evicted, want.evicted));
                if (o_evicted_key !== want.evicted_key)
                    report_mismatch($sformatf("evicted_key %h, want %h",
                                              o_evicted_key, want.evicted_key));
                if (o_occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              o_occupancy, want.occupancy));
            end
        end
    end

    // Mostly back-to-back or short, now and then long enough to leave the block idle.
    function automatic int next_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 24);
        return $urandom_range(25, 80);
    endfunction

    // Hold start until the item is taken; drop it only when a gap follows.
    task automatic send_item(logic [1:0] cmd, logic [lfu_pkg::KEY_W-1:0] key,
                             logic [lfu_pkg::DATA_W-1:0] val, int gap);
        start     <= 1'b1;
        i_command <= cmd;
        i_key     <= key;
        i_value   <= val;
        do @(posedge i_clk); while (busy);
        cache_replies.insert(cache_replies.size(), lfu_apply(cmd, key, val));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic set_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
        start <= 1'b0;
        while (cache_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        capacity_reg = cap;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_hits_and_misses();
        send_item(lfu_pkg::CMD_PROBE, 32'h0000_0000, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_GET,   32'hFFFF_FFFF, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_PUT,   32'h0000_0000, 32'hFFFF_FFFF, next_gap());
        send_item(lfu_pkg::CMD_PUT,   32'hFFFF_FFFF, 32'h0000_0000, next_gap());
        send_item(lfu_pkg::CMD_PUT,   32'hA5A5_A5A5, 32'h5A5A_5A5A, next_gap());
        send_item(lfu_pkg::CMD_GET,   32'h0000_0000, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_PROBE, 32'hFFFF_FFFF, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_PUT,   32'h0000_0000, 32'h1234_5678, next_gap());
        send_item(lfu_pkg::CMD_PROBE, 32'h0000_0000, $urandom(), next_gap());
        send_item(CMD_NONE,           32'h0000_0000, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_GET,   32'h5A5A_5A5A, $urandom(), next_gap());
    endtask

    task automatic test_lfu_eviction();
        // count ties fall back to the least recently touched entry
        set_capacity(5'd3);
        send_item(lfu_pkg::CMD_PUT, 32'h0000_0001, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_GET, 32'h0000_0001, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_GET, 32'h0000_0001, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_PUT, 32'h0000_0002, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_PUT, 32'h0000_0003, $urandom(), next_gap());
        // capacity below occupancy: evict and insert, occupancy holds
        set_capacity(5'd1);
        send_item(lfu_pkg::CMD_PUT, 32'h0000_0004, $urandom(), next_gap());
        set_capacity(5'd0);
        send_item(lfu_pkg::CMD_PUT, 32'h0000_0005, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_GET, 32'h0000_0005, $urandom(), next_gap());
        set_capacity(5'd31);
        send_item(lfu_pkg::CMD_PUT, 32'h0000_0006, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_PUT, 32'h0000_0007, $urandom(), next_gap());
    endtask

    task automatic test_hot_entry();
        logic [lfu_pkg::KEY_W-1:0] hot_key;
        hot_key = $urandom();
        set_capacity(5'd2);
        send_item(lfu_pkg::CMD_PUT, hot_key, $urandom(), 0);
        // keep one entry far ahead in count so newer keys evict each other
        repeat (HOT_GETS)
            send_item(lfu_pkg::CMD_GET, hot_key, $urandom(), 0);
        send_item(lfu_pkg::CMD_PUT, hot_key ^ 32'h0000_0001, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_PUT, hot_key ^ 32'h0000_0002, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_PUT, hot_key ^ 32'h0000_0004, $urandom(), next_gap());
        send_item(lfu_pkg::CMD_GET, hot_key, $urandom(), next_gap());
    endtask

    task automatic test_random_traffic();
        logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
        logic [lfu_pkg::CAP_W-1:0] phase_caps [7];
        logic [1:0]                cmd;
        logic [lfu_pkg::KEY_W-1:0] key;
        int                        pick;
        int                        pool_span;
        int                        per_phase;
        bit                        dense;
        int                        p;
        int                        n;
        phase_caps = '{5'd4, 5'd16, 5'd0, 5'd31, 5'd9, 5'd17, 5'd0};
        phase_caps[6] = lfu_pkg::CAP_W'($urandom_range(0, 31));
        per_phase = RANDOM_ITEMS / 7;
        dense     = 1'b0;
        for (n = 0; n < POOL_SIZE; n++)
            key_pool[n] = $urandom();
        for (p = 0; p < 7; p++) begin
            set_capacity(phase_caps[p]);
            pool_span = $urandom_range(3, POOL_SIZE);
            for (n = 0; n < per_phase; n++) begin
                if (n % 40 == 0)
                    dense = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 29) == 0)
                    key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
                pick = $urandom_range(0, 99);
                cmd  = (pick < 45) ? lfu_pkg::CMD_PUT :
                       (pick < 78) ? lfu_pkg::CMD_GET :
                       (pick < 95) ? lfu_pkg::CMD_PROBE : CMD_NONE;
                key  = ($urandom_range(0, 9) == 0) ? $urandom()
                                                    : key_pool[$urandom_range(0, pool_span - 1)];
                send_item(cmd, key, $urandom(), dense ? 0 : next_gap());
            end
        end
    endtask

    initial begin
        int i;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_command   <= lfu_pkg::CMD_PUT;
        i_key       <= '0;
        i_value     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        for (i = 0; i < lfu_pkg::ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_data[i]  = '0;
            slot_uses[i]  = '0;
            slot_age[i]   = '0;
        end
        live_slots   = 0;
        capacity_reg = lfu_pkg::CAP_W'(16);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_hits_and_misses();
        test_lfu_eviction();
        test_hot_entry();
        test_random_traffic();

        start <= 1'b0;
        while (cache_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
